@@ hw/rtl/fat_chain_allocator_macros.svh @@
// Assertion macros used by the allocator top level.
`ifndef FAT_CHAIN_ALLOCATOR_MACROS_SVH
`define FAT_CHAIN_ALLOCATOR_MACROS_SVH
`ifndef SYNTH
`define FCA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");
`define FCA_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");
`else
`define FCA_ASSERT_IMP(label, clk, rst, ante, cons)
`define FCA_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

@@ hw/rtl/fca_pkg.sv @@
// Shared constants, codes and controller/datapath interface types.
package fca_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 2048;
  localparam int unsigned IDX_W  = 11;
  localparam int unsigned ACT_W  = 3;
  localparam int unsigned WORD_W = 16;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [ACT_W-1:0] ACT_FORMAT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_START  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_EXTEND = 3'd2;
  localparam logic [ACT_W-1:0] ACT_NEXT   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_LOAD   = 3'd4;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
  localparam logic [ST_W-1:0] ST_NOCHAIN = 2'd2;

  // Register select taken from paddr bit 2.
  localparam logic REG_FREE = 1'b0;
  localparam logic REG_END  = 1'b1;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_FORMAT,
    WR_TAIL_END,
    WR_TAIL_LINK,
    WR_FOUND_END,
    WR_LOAD
  } wr_sel_t;

  typedef enum logic [2:0] {
    RESP_ZERO,
    RESP_FULL,
    RESP_NOCHAIN,
    RESP_FOUND,
    RESP_READ
  } resp_t;

  typedef struct packed {
    logic    capture;
    logic    cnt_clr;
    logic    fmt_step;
    logic    scan_step;
    logic    rd_index;
    wr_sel_t wr_sel;
    logic    found_load;
    logic    chain_set;
    logic    chain_clear;
    logic    out_load;
    resp_t   resp;
  } dp_cmd_t;

  typedef struct packed {
    logic idx_ok;
    logic chain_open;
    logic scan_hit;
    logic scan_done;
    logic fmt_last;
  } dp_sts_t;

endpackage

@@ hw/rtl/fca_dp.sv @@
// Datapath: link table memory, scan counter, chain registers and result register.
module fca_dp #(
  parameter int unsigned TABLE_ENTRIES = fca_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  fca_pkg::dp_cmd_t            cmd,
  output fca_pkg::dp_sts_t            sts,
  input  logic [fca_pkg::IDX_W-1:0]   block_index,
  input  logic [fca_pkg::WORD_W-1:0]  entry_value,
  input  logic [fca_pkg::WORD_W-1:0]  free_marker,
  input  logic [fca_pkg::WORD_W-1:0]  end_marker,
  output logic [fca_pkg::ST_W-1:0]    status,
  output logic [fca_pkg::WORD_W-1:0]  block_out,
  output logic                        is_end
);

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned XW = fca_pkg::WORD_W + 1;
  localparam logic [CW-1:0] CNT_END  = CW'(TABLE_ENTRIES);
  localparam logic [CW-1:0] CNT_LAST = CW'(TABLE_ENTRIES - 1);
  localparam logic [CW-1:0] CNT_TWO  = CW'(2);

  logic [fca_pkg::WORD_W-1:0] mem [TABLE_ENTRIES];

  logic [AW-1:0]              idx;
  logic [fca_pkg::WORD_W-1:0] val;
  logic [AW-1:0]              found;
  logic [AW-1:0]              tail;
  logic                       chain_open;
  logic [CW-1:0]              cnt;
  logic                       pend;
  logic [fca_pkg::WORD_W-1:0] rd_data;
  logic [AW-1:0]              rd_addr_q;

  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [fca_pkg::WORD_W-1:0] wr_data;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic                       scan_issue;

  assign scan_issue = cmd.scan_step && (cnt < CNT_END);
  assign rd_en      = scan_issue || cmd.rd_index;
  assign rd_addr    = cmd.rd_index ? idx : cnt[AW-1:0];

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = '0;
    wr_data = '0;
    unique case (cmd.wr_sel)
      fca_pkg::WR_FORMAT: begin
        wr_addr = cnt[AW-1:0];
        wr_data = (cnt < CNT_TWO) ? end_marker : free_marker;
      end
      fca_pkg::WR_TAIL_END: begin
        wr_addr = tail;
        wr_data = end_marker;
      end
      fca_pkg::WR_TAIL_LINK: begin
        wr_addr = tail;
        wr_data = fca_pkg::WORD_W'(found);
      end
      fca_pkg::WR_FOUND_END: begin
        wr_addr = found;
        wr_data = end_marker;
      end
      fca_pkg::WR_LOAD: begin
        wr_addr = idx;
        wr_data = val;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data   <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  assign sts.idx_ok     = XW'(block_index) < XW'(TABLE_ENTRIES);
  assign sts.chain_open = chain_open;
  assign sts.scan_hit   = pend && (rd_data == free_marker);
  assign sts.scan_done  = !pend && (cnt == CNT_END);
  assign sts.fmt_last   = (cnt == CNT_LAST);

  // Item fields and the found index.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx <= AW'(block_index);
      val <= entry_value;
    end
    if (cmd.found_load) begin
      found <= rd_addr_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      pend       <= 1'b0;
      tail       <= '0;
      chain_open <= 1'b0;
    end else begin
      if (cmd.cnt_clr) begin
        cnt <= '0;
      end else if (cmd.fmt_step || scan_issue) begin
        cnt <= cnt + CW'(1);
      end
      pend <= scan_issue && !cmd.cnt_clr;
      if (cmd.chain_clear) begin
        tail       <= '0;
        chain_open <= 1'b0;
      end else if (cmd.chain_set) begin
        tail       <= found;
        chain_open <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      unique case (cmd.resp)
        fca_pkg::RESP_FULL: begin
          status    <= fca_pkg::ST_FULL;
          block_out <= '0;
          is_end    <= 1'b0;
        end
        fca_pkg::RESP_NOCHAIN: begin
          status    <= fca_pkg::ST_NOCHAIN;
          block_out <= '0;
          is_end    <= 1'b0;
        end
        fca_pkg::RESP_FOUND: begin
          status    <= fca_pkg::ST_OK;
          block_out <= fca_pkg::WORD_W'(found);
          is_end    <= 1'b0;
        end
        fca_pkg::RESP_READ: begin
          status    <= fca_pkg::ST_OK;
          block_out <= rd_data;
          is_end    <= (rd_data == end_marker);
        end
        default: begin
          status    <= fca_pkg::ST_OK;
          block_out <= '0;
          is_end    <= 1'b0;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/fca_ctrl.sv @@
// Controller: sequences format, free-block scan, chain update, table read and load, and result handoff.
module fca_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [fca_pkg::ACT_W-1:0]  action,
  output logic                       out_valid,
  input  logic                       out_stall,
  output fca_pkg::dp_cmd_t           cmd,
  input  fca_pkg::dp_sts_t           sts
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FORMAT,
    S_TAIL,
    S_SCAN,
    S_LINK,
    S_MARK,
    S_READ,
    S_LOAD,
    S_RESP
  } state_t;

  state_t                      state;
  logic [fca_pkg::ACT_W-1:0]   act;
  fca_pkg::resp_t              resp;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd.capture     = 1'b0;
    cmd.cnt_clr     = 1'b0;
    cmd.fmt_step    = 1'b0;
    cmd.scan_step   = 1'b0;
    cmd.rd_index    = 1'b0;
    cmd.wr_sel      = fca_pkg::WR_NONE;
    cmd.found_load  = 1'b0;
    cmd.chain_set   = 1'b0;
    cmd.chain_clear = 1'b0;
    cmd.out_load    = 1'b0;
    cmd.resp        = resp;
    unique case (state)
      S_IDLE: begin
        cmd.capture = in_valid;
        cmd.cnt_clr = in_valid;
      end
      S_FORMAT: begin
        cmd.wr_sel      = fca_pkg::WR_FORMAT;
        cmd.fmt_step    = 1'b1;
        cmd.chain_clear = 1'b1;
      end
      S_TAIL:  cmd.wr_sel = fca_pkg::WR_TAIL_END;
      S_SCAN: begin
        cmd.scan_step  = 1'b1;
        cmd.found_load = sts.scan_hit;
      end
      S_LINK:  cmd.wr_sel = fca_pkg::WR_TAIL_LINK;
      S_MARK: begin
        cmd.wr_sel    = fca_pkg::WR_FOUND_END;
        cmd.chain_set = 1'b1;
      end
      S_READ:  cmd.rd_index = 1'b1;
      S_LOAD:  cmd.wr_sel = fca_pkg::WR_LOAD;
      S_RESP:  cmd.out_load = !out_valid || !out_stall;
      default: cmd.capture = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      act       <= fca_pkg::ACT_FORMAT;
      resp      <= fca_pkg::RESP_ZERO;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            act  <= action;
            resp <= ((action == fca_pkg::ACT_EXTEND) && !sts.chain_open) ?
                    fca_pkg::RESP_NOCHAIN : fca_pkg::RESP_ZERO;
            unique case (action)
              fca_pkg::ACT_FORMAT: state <= S_FORMAT;
              fca_pkg::ACT_START:  state <= S_SCAN;
              fca_pkg::ACT_EXTEND: state <= sts.chain_open ? S_TAIL : S_RESP;
              fca_pkg::ACT_NEXT:   state <= sts.idx_ok ? S_READ : S_RESP;
              fca_pkg::ACT_LOAD:   state <= sts.idx_ok ? S_LOAD : S_RESP;
              default:             state <= S_RESP;
            endcase
          end
        end
        S_FORMAT: begin
          if (sts.fmt_last) begin
            state <= S_RESP;
          end
        end
        S_TAIL: state <= S_SCAN;
        S_SCAN: begin
          priority if (sts.scan_hit) begin
            state <= (act == fca_pkg::ACT_EXTEND) ? S_LINK : S_MARK;
          end else if (sts.scan_done) begin
            resp  <= fca_pkg::RESP_FULL;
            state <= S_RESP;
          end
        end
        S_LINK: state <= S_MARK;
        S_MARK: begin
          resp  <= fca_pkg::RESP_FOUND;
          state <= S_RESP;
        end
        S_READ: begin
          resp  <= fca_pkg::RESP_READ;
          state <= S_RESP;
        end
        S_LOAD: state <= S_RESP;
        S_RESP: begin
          if (cmd.out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/fat_chain_allocator.sv @@
// Top level of the file allocation table chain allocator.
//
// Usage: items enter on in_valid/in_stall with fields action, block_index and
// entry_value; every item produces exactly one result on out_valid/out_stall
// with fields status, block_out and is_end. An item is taken when valid is
// high and stall is low at a rising clock edge. The block works on one item
// at a time and holds in_stall high from acceptance until the result is
// placed in the output register. The input side is free again while that
// result still waits, so the next item can start under a stalled receiver;
// its own result waits until the output register empties.
// Next-of and load make one table access before the result; an extend with no
// open chain, an index outside the table or an unused action go straight to
// the result. Format writes every entry in turn; start chain scans for a free
// entry and marks it; extend chain closes the tail, scans, links and marks.
// The next item can be taken in the cycle after the result is loaded. Format
// and the free search step through the single-port table one entry per cycle.
// Reset clears the controller, closes the chain and empties the output; the
// table itself holds garbage until a format or loads write it. The user must
// write the markers through the APB port only while the block is idle; the block itself does not enforce this.

`include "fat_chain_allocator_macros.svh"

module fat_chain_allocator #(
  parameter int unsigned TABLE_ENTRIES = fca_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [fca_pkg::ACT_W-1:0]    action,
  input  logic [fca_pkg::IDX_W-1:0]    block_index,
  input  logic [fca_pkg::WORD_W-1:0]   entry_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [fca_pkg::ST_W-1:0]     status,
  output logic [fca_pkg::WORD_W-1:0]   block_out,
  output logic                         is_end,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fca_pkg::PADDR_W-1:0]  paddr,
  input  logic [fca_pkg::PDATA_W-1:0]  pwdata,
  output logic [fca_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  fca_pkg::dp_cmd_t           cmd;
  fca_pkg::dp_sts_t           sts;
  logic [fca_pkg::WORD_W-1:0] free_marker;
  logic [fca_pkg::WORD_W-1:0] end_marker;

  // Configuration registers. The port never waits; bit 2 of the byte address
  // picks the register, and only the low 16 bits of the data are kept.
  assign pready = 1'b1;
  assign prdata = fca_pkg::PDATA_W'((paddr[2] == fca_pkg::REG_END) ? end_marker
                                                                    : free_marker);

  always_ff @(posedge clk) begin
    if (rst) begin
      free_marker <= '0;
      end_marker  <= '1;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == fca_pkg::REG_END) begin
        end_marker <= pwdata[fca_pkg::WORD_W-1:0];
      end else begin
        free_marker <= pwdata[fca_pkg::WORD_W-1:0];
      end
    end
  end

  fca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  fca_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .block_index (block_index),
    .entry_value (entry_value),
    .free_marker (free_marker),
    .end_marker  (end_marker),
    .status      (status),
    .block_out   (block_out),
    .is_end      (is_end)
  );

  // Every accepted item takes the controller out of idle, so in_stall is high once it is taken.
  `FCA_ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  // Only the three defined status codes ever leave the block.
  `FCA_ASSERT_IMP(a_status_legal, clk, rst, out_valid, status <= fca_pkg::ST_NOCHAIN)
  // The end flag comes only from a successful next-of read.
  `FCA_ASSERT_IMP(a_end_only_ok, clk, rst, out_valid && is_end, status == fca_pkg::ST_OK)
  // A failed allocation reports no block.
  `FCA_ASSERT_IMP(a_fail_zero, clk, rst, out_valid && (status != fca_pkg::ST_OK), block_out == '0)

endmodule

@@ dv/fat_alloc_tb_pkg.sv @@
// Result type and table shadow with expected-result queue for the chain allocator bench.
`timescale 1ns / 100ps

package fat_alloc_tb_pkg;
  import fca_pkg::*;

  localparam int TABLE_SIZE = int'(TABLE_ENTRIES_DEF);

  // Actions the block accepts but does nothing with.
  localparam logic [ACT_W-1:0] ACT_SPARE_A = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SPARE_C = 3'd7;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [WORD_W-1:0] block_out;
    logic              is_end;
  } alloc_result_t;

  class fat_table_shadow;
    logic [WORD_W-1:0] link_tab [TABLE_SIZE];
    logic [IDX_W-1:0]  chain_tail;
    logic              chain_open;
    logic [WORD_W-1:0] free_mark;
    logic [WORD_W-1:0] end_mark;
    alloc_result_t     due_results [$];
    int                n_errors;
    int                n_checked;

    function new();
      chain_tail = '0;
      chain_open = 1'b0;
      free_mark  = 16'h0000;
      end_mark   = 16'hFFFF;
      n_errors   = 0;
      n_checked  = 0;
      foreach (link_tab[i]) link_tab[i] = '0;
    endfunction

    function void set_marker(logic reg_sel, logic [WORD_W-1:0] value);
      if (reg_sel == REG_FREE) begin
        free_mark = value;
      end else begin
        end_mark = value;
      end
    endfunction

    function int lowest_free();
      for (int i = 0; i < TABLE_SIZE; i++) begin
        if (link_tab[i] == free_mark) return i;
      end
      return -1;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // Applies one accepted item to the shadow table and queues its result.
    function void note_item(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx,
                            logic [WORD_W-1:0] value);
      alloc_result_t r;
      int            hit;
      r = '0;
      r.status = ST_OK;
      case (act)
        ACT_FORMAT: begin
          link_tab[0] = end_mark;
          link_tab[1] = end_mark;
          for (int i = 2; i < TABLE_SIZE; i++) link_tab[i] = free_mark;
          chain_open = 1'b0;
          chain_tail = '0;
        end
        ACT_START: begin
          hit = lowest_free();
          if (hit < 0) begin
            r.status = ST_FULL;
          end else begin
            link_tab[hit] = end_mark;
            chain_tail    = hit[IDX_W-1:0];
            chain_open    = 1'b1;
            r.block_out   = hit[WORD_W-1:0];
          end
        end
        ACT_EXTEND: begin
          if (!chain_open) begin
            r.status = ST_NOCHAIN;
          end else begin
            // The tail is closed before the search, which matters when the
            // two markers are equal.
            link_tab[chain_tail] = end_mark;
            hit = lowest_free();
            if (hit < 0) begin
              r.status = ST_FULL;
            end else begin
              link_tab[chain_tail] = hit[WORD_W-1:0];
              link_tab[hit]        = end_mark;
              chain_tail           = hit[IDX_W-1:0];
              r.block_out          = hit[WORD_W-1:0];
            end
          end
        end
        ACT_NEXT: begin
          if (int'(idx) < TABLE_SIZE) begin
            r.block_out = link_tab[idx];
            r.is_end    = (link_tab[idx] == end_mark);
          end
        end
        ACT_LOAD: begin
          if (int'(idx) < TABLE_SIZE) link_tab[idx] = value;
        end
        default: begin
        end
      endcase
      due_results.insert(due_results.size(), r);
    endfunction

    function void check_result(logic [ST_W-1:0] status, logic [WORD_W-1:0] block_out,
                               logic is_end);
      alloc_result_t want;
      n_checked++;
      if (due_results.size() == 0) begin
        $error("result with no item waiting: status %0d, block_out %0d, is_end %0d",
               status, block_out, is_end);
        n_errors++;
        return;
      end
      want = due_results.pop_front();
      if (status !== want.status) begin
        $error("status mismatch: expected %0d, got %0d", want.status, status);
        n_errors++;
      end
      if (block_out !== want.block_out) begin
        $error("block_out mismatch: expected %0d, got %0d", want.block_out, block_out);
        n_errors++;
      end
      if (is_end !== want.is_end) begin
        $error("is_end mismatch: expected %0d, got %0d", want.is_end, is_end);
        n_errors++;
      end
    endfunction
  endclass

endpackage

@@ dv/tb_top.sv @@
// Top-level bench for the chain allocator: clocking, drivers, monitor and test sequence.
`timescale 1ns / 100ps

module tb_top;
  import fca_pkg::*;
  import fat_alloc_tb_pkg::*;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid;
  logic                in_stall;
  logic [ACT_W-1:0]    action;
  logic [IDX_W-1:0]    block_index;
  logic [WORD_W-1:0]   entry_value;
  logic                out_valid;
  logic                out_stall;
  logic [ST_W-1:0]     status;
  logic [WORD_W-1:0]   block_out;
  logic                is_end;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  // The shadow holds the predicted table, chain state and markers, and the
  // queue of results that accepted items still owe.
  fat_table_shadow shadow = new();

  // Items handed to the block so far; it steers the quiet window of the sender.
  int n_sent = 0;
  int readback_errors = 0;

  fat_chain_allocator u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .block_index (block_index),
    .entry_value (entry_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .block_out   (block_out),
    .is_end      (is_end),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk = ~clk;

  // Both handshakes are observed at the rising edge. The input is noted
  // before the output is checked, which is safe because a result leaving in
  // the same cycle always belongs to an earlier item.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) shadow.note_item(action, block_index, entry_value);
      if (out_valid && !out_stall) shadow.check_result(status, block_out, is_end);
    end
  end

  // The run is bounded by a fixed time far beyond the slowest legal run: every
  // item doing a full table scan plus the stall stretches.
  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Receiver. It stalls about a quarter of the cycles, stays quiet over a
  // window of results, and once holds off for a long stretch so that a result
  // sits in the output register, the next item finishes behind it, and the
  // input side backs up while the sender keeps offering.
  initial begin
    logic long_hold_done;
    logic rx_quiet;
    long_hold_done = 1'b0;
    out_stall = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (!long_hold_done && shadow.n_checked >= 60) begin
        long_hold_done = 1'b1;
        out_stall = 1'b1;
        repeat (300) @(negedge clk);
      end
      rx_quiet = (shadow.n_checked >= 120 && shadow.n_checked < 180);
      out_stall = !rx_quiet && ($urandom_range(0, 99) < 24);
    end
  end

  function automatic logic [IDX_W-1:0] any_index();
    return IDX_W'($urandom);
  endfunction

  function automatic logic [WORD_W-1:0] any_word();
    return WORD_W'($urandom);
  endfunction

  // Every task below starts and ends at a falling edge, so inputs only ever
  // change half a period away from the edge at which the block samples them.
  task automatic send_item(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] idx,
                           input logic [WORD_W-1:0] value);
    logic tx_quiet;
    tx_quiet = (n_sent >= 150 && n_sent < 200);
    while (!tx_quiet && $urandom_range(0, 99) < 24) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    action      = act;
    block_index = idx;
    entry_value = value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // By the next falling edge the monitor has updated the shadow, so the
    // caller may read the predicted table to build the following items.
    @(negedge clk);
    n_sent++;
  endtask

  // Lets every owed result come out and then waits on, so the block is
  // surely idle before a marker write or the end of the run.
  task automatic wait_all_results();
    in_valid = 1'b0;
    while (shadow.pending() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // Writes one marker through the APB port, mirrors it into the shadow and
  // reads it back.
  task automatic write_marker(input logic reg_sel, input logic [WORD_W-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {reg_sel, 2'b00};
    pwdata  = {{(PDATA_W - WORD_W){1'b0}}, value};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    shadow.set_marker(reg_sel, value);
    @(negedge clk);
    psel = 1'b1;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[WORD_W-1:0] !== value) begin
      $error("marker readback mismatch: expected %0d, got %0d", value, prdata[WORD_W-1:0]);
      readback_errors++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Random traffic under the current markers. It opens with a format so the
  // table matches the markers, then mostly builds chains (a start, a few
  // extends, and a walk of next-of reads from the head along the links the
  // shadow predicts), mixed with loads, stray reads, lone starts and extends, spare
  // actions and an occasional format. Spare actions are not counted.
  task automatic run_random_phase(input int n_items, input int pause_at);
    int                done;
    int                roll;
    int                n_ext;
    logic              paused;
    logic [IDX_W-1:0]  head;
    logic [IDX_W-1:0]  blk;
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] value;
    done   = 1;
    paused = 1'b0;
    send_item(ACT_FORMAT, any_index(), any_word());
    while (done < n_items) begin
      if (!paused && done >= pause_at) begin
        // The sender waits here until nothing is owed any more.
        paused = 1'b1;
        wait_all_results();
      end
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        send_item(ACT_START, any_index(), any_word());
        head  = shadow.chain_tail;
        n_ext = $urandom_range(0, 5);
        repeat (n_ext) send_item(ACT_EXTEND, any_index(), any_word());
        blk = head;
        repeat (n_ext + 1) begin
          send_item(ACT_NEXT, blk, any_word());
          blk = shadow.link_tab[blk][IDX_W-1:0];
        end
        done += 2 * n_ext + 2;
      end else if (roll < 67) begin
        // Loads favor the low entries, where the free search looks first,
        // and favor the marker values so blocks get freed and taken.
        idx = ($urandom_range(0, 1) == 0) ? IDX_W'($urandom_range(0, 63)) : any_index();
        case ($urandom_range(0, 3))
          0:       value = shadow.free_mark;
          1:       value = shadow.end_mark;
          2:       value = WORD_W'($urandom_range(0, TABLE_SIZE - 1));
          default: value = any_word();
        endcase
        send_item(ACT_LOAD, idx, value);
        done++;
      end else if (roll < 82) begin
        idx = ($urandom_range(0, 1) == 0) ? IDX_W'($urandom_range(0, 63)) : any_index();
        send_item(ACT_NEXT, idx, any_word());
        done++;
      end else if (roll < 87) begin
        send_item(ACT_EXTEND, any_index(), any_word());
        done++;
      end else if (roll < 90) begin
        send_item(ACT_W'($urandom_range(ACT_SPARE_C, ACT_SPARE_A)), any_index(), any_word());
      end else if (roll < 92) begin
        send_item(ACT_FORMAT, any_index(), any_word());
        done++;
      end else begin
        send_item(ACT_START, any_index(), any_word());
        done++;
      end
    end
  endtask

  initial begin
    logic [WORD_W-1:0] mark;
    in_valid    = 1'b0;
    action      = ACT_FORMAT;
    block_index = '0;
    entry_value = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    repeat (8) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed part under the reset markers. The table holds garbage after
    // reset, so the very first item is a format and nothing reads it before.
    send_item(ACT_FORMAT, 11'd0, 16'h0000);
    send_item(ACT_EXTEND, 11'd0, 16'h0000);          // no chain open yet
    send_item(ACT_NEXT, 11'd0, 16'h0000);            // entry 0 holds the end marker
    send_item(ACT_NEXT, 11'd2, 16'h0000);            // a free entry
    send_item(ACT_START, 11'd0, 16'h0000);           // lowest free is 2
    send_item(ACT_EXTEND, 11'd0, 16'h0000);
    send_item(ACT_LOAD, 11'd4, 16'hFFFF);            // take block 4 by hand
    send_item(ACT_EXTEND, 11'd0, 16'h0000);          // the search skips block 4
    send_item(ACT_NEXT, 11'd2, 16'h0000);
    send_item(ACT_NEXT, 11'd5, 16'h0000);
    send_item(ACT_LOAD, 11'd0, 16'h0000);            // free entry 0
    send_item(ACT_START, 11'd2047, 16'hFFFF);        // reuses entry 0
    send_item(ACT_NEXT, 11'd2047, 16'h0000);
    send_item(ACT_LOAD, 11'd2047, 16'hFFFF);
    send_item(ACT_NEXT, 11'd2047, 16'hFFFF);
    send_item(ACT_SPARE_A, 11'd2047, 16'hFFFF);
    send_item(ACT_W'(ACT_SPARE_A + 3'd1), 11'd1, 16'h5555);
    send_item(ACT_SPARE_C, 11'd0, 16'hAAAA);
    send_item(ACT_LOAD, 11'd1024, 16'h1234);

    // With the free marker matching one entry only, the search runs to the
    // middle of the table; after that the table is full, and a failed extend
    // must leave the open chain as it was.
    wait_all_results();
    write_marker(REG_FREE, 16'h1234);
    send_item(ACT_START, 11'd0, 16'h0000);
    send_item(ACT_START, 11'd0, 16'h0000);
    send_item(ACT_EXTEND, 11'd0, 16'h0000);
    send_item(ACT_NEXT, 11'd1024, 16'h0000);

    // Equal markers: blocks marked end-of-chain count as free, so an extend
    // finds its own freshly closed tail.
    wait_all_results();
    write_marker(REG_FREE, 16'hFFFF);
    send_item(ACT_START, 11'd0, 16'h0000);
    send_item(ACT_EXTEND, 11'd0, 16'h0000);
    send_item(ACT_NEXT, 11'd0, 16'h0000);

    // Random phases, each under its own pair of markers: the reset values,
    // the swapped extremes (with a full drain halfway), a random distinct
    // pair, and a random equal pair.
    wait_all_results();
    write_marker(REG_FREE, 16'h0000);
    write_marker(REG_END, 16'hFFFF);
    run_random_phase(66, 1000);

    wait_all_results();
    write_marker(REG_FREE, 16'hFFFF);
    write_marker(REG_END, 16'h0000);
    run_random_phase(66, 30);

    wait_all_results();
    mark = any_word();
    write_marker(REG_FREE, mark);
    write_marker(REG_END, mark ^ 16'h8001);
    run_random_phase(66, 1000);

    wait_all_results();
    mark = any_word();
    write_marker(REG_FREE, mark);
    write_marker(REG_END, mark);
    run_random_phase(66, 1000);

    wait_all_results();
    if (shadow.n_errors == 0 && readback_errors == 0 && shadow.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
